// ===== hdl/pngupe_pkg.sv =====
// Shared types, codes and helper functions for the indexed PNG unfilter and palette expander.
// Has no dependencies. It is compiled before the core.
`default_nettype none

package pngupe_pkg;

	typedef enum logic {
		OP_PALETTE = 1'b0,
		OP_STREAM  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_ROW_PIXELS   = 2'd0,
		CFG_IMAGE_ROWS   = 2'd1,
		CFG_DEPTH_CODE   = 2'd2,
		CFG_PALETTE_SIZE = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_FILTER = 2'd1,
		ERR_INDEX  = 2'd2
	} err_t;

	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	localparam logic [1:0] DEPTH_1 = 2'd0;
	localparam logic [1:0] DEPTH_2 = 2'd1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	// item held in the reconstruction stage
	typedef struct packed {
		logic        is_filt;
		logic        bad_filt;
		logic [7:0]  raw;
		logic [2:0]  filt;
		logic        up_zero;
		logic        fwd;
		logic [7:0]  fwd_data;
		logic [12:0] x;
		logic        x_in;
		logic        row_last;
		logic        img_end;
	} s1_item_t;

	// item held in the unpacker
	typedef struct packed {
		logic       is_filt;
		logic       bad_filt;
		logic [7:0] pix;
		logic       row_last;
		logic       img_end;
	} s2_item_t;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [9:0] sa, sb, sc, p, da, db, dc;
		sa = $signed({2'b00, a});
		sb = $signed({2'b00, b});
		sc = $signed({2'b00, c});
		p  = sa + sb - sc;
		da = p - sa;
		db = p - sb;
		dc = p - sc;
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) return a;
		return (db <= dc) ? b : c;
	endfunction

	function automatic logic [7:0] recon(input logic [2:0] filt, input logic [7:0] raw,
			input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
		logic [8:0] avg_sum;
		avg_sum = {1'b0, a} + {1'b0, b};
		unique case (filt)
			FILT_SUB:   return raw + a;
			FILT_UP:    return raw + b;
			FILT_AVG:   return raw + avg_sum[8:1];
			FILT_PAETH: return raw + paeth(a, b, c);
			default:    return raw;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== hdl/png_unfilter_palette_expand_core.sv =====
// Indexed PNG scanline unfilter with palette expansion to RGBA pixels.
// Depends on pngupe_pkg (codes, item structs, reconstruction functions).
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_stall   | operation, entry_*, data_byte
//  out     | out_valid / out_stall | red, green, blue, alpha, end_of_row,
//          |                       | end_of_image, last, error_code
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (ready is always high)
//
// A stream byte stays in the unpacker until it has yielded its pixel results (up to 8
// at one bit per index); the unpacker sets the rate, one result per cycle unless stalled.
// Path of a byte: line store read and reconstruction, unpacker, output register.
// Palette writes wait until no stream byte is in flight.
// Reset clears counters and palette, loads config defaults; the line store needs no clearing.
// A stalled output holds the unpacker, which in turn holds the input.
`default_nettype none

module png_unfilter_palette_expand_core import pngupe_pkg::*; #(
	parameter int MAX_ROW_PIXELS = 4096,
	parameter int PALETTE_DEPTH  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [3:0]  entry_index,
	input  wire logic [7:0]  entry_red,
	input  wire logic [7:0]  entry_green,
	input  wire logic [7:0]  entry_blue,
	input  wire logic [7:0]  entry_alpha,
	input  wire logic [7:0]  data_byte,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic             end_of_row,
	output logic             end_of_image,
	output logic             last,
	output logic [1:0]       error_code,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int LINE_BYTES = (MAX_ROW_PIXELS * 4 + 7) / 8;
	localparam int AW         = $clog2(LINE_BYTES);
	localparam int PW         = $clog2(PALETTE_DEPTH);

	// configuration
	logic [12:0] row_pixels_q;
	logic [15:0] image_rows_q;
	logic [1:0]  depth_code_q;
	logic [4:0]  palette_size_q;

	logic [12:0] width;
	logic [15:0] rows;
	logic [12:0] row_bytes;
	logic [4:0]  pal;
	logic [2:0]  per_m1;
	logic [2:0]  shift_bits;

	// front end
	logic        in_fire, byte_fire, pal_fire;
	logic [12:0] byte_column_q;
	logic [15:0] row_count_q;
	logic [2:0]  row_filter_q;
	logic        at_filter;
	logic [12:0] x;
	logic        x_in;
	logic [13:0] bc_next;
	logic        row_done;
	logic [16:0] rc_next;
	logic        img_done;

	// line store and reconstruction
	logic [7:0]  line_mem [LINE_BYTES];
	logic [7:0]  rd_data_q;
	s1_item_t    s1_q;
	logic        s1_valid_q;
	logic        s1_fire;
	logic [7:0]  left_q, ul_q;
	logic [7:0]  up;
	logic [7:0]  rec;
	logic        mem_we;

	// unpacker
	s2_item_t    s2_q;
	logic        s2_busy_q;
	logic [2:0]  k_q;
	logic [12:0] pix_col_q;
	logic        err_latch_q;
	logic [31:0] palette_q [PALETTE_DEPTH];
	logic        out_ready;
	logic [3:0]  idx;
	logic        bad_idx;
	logic        pix_last;
	logic        emit;
	logic        s2_done;
	err_t        err_kind;
	logic [31:0] pal_entry;
	logic        eor;

	// output register
	logic        out_valid_q;
	logic [7:0]  red_q, green_q, blue_q, alpha_q;
	logic        eor_q, eoi_q, last_q;
	err_t        err_q;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pixels_q   <= 13'd1;
			image_rows_q   <= 16'd1;
			depth_code_q   <= DEPTH_1;
			palette_size_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROW_PIXELS:   row_pixels_q   <= cfg_data[12:0];
				CFG_IMAGE_ROWS:   image_rows_q   <= cfg_data;
				CFG_DEPTH_CODE:   depth_code_q   <= cfg_data[1:0];
				CFG_PALETTE_SIZE: palette_size_q <= cfg_data[4:0];
			endcase
		end
	end

	always_comb begin
		if (row_pixels_q == 13'd0)
			width = 13'd1;
		else if (32'(row_pixels_q) > MAX_ROW_PIXELS)
			width = 13'(MAX_ROW_PIXELS);
		else
			width = row_pixels_q;
		rows = (image_rows_q == 16'd0) ? 16'd1 : image_rows_q;
		pal  = (32'(palette_size_q) > PALETTE_DEPTH) ? 5'(PALETTE_DEPTH) : palette_size_q;
		unique case (depth_code_q)
			DEPTH_1: begin
				row_bytes  = 13'((14'(width) + 14'd7) >> 3);
				per_m1     = 3'd7;
				shift_bits = 3'd1;
			end
			DEPTH_2: begin
				row_bytes  = 13'((14'(width) + 14'd3) >> 2);
				per_m1     = 3'd3;
				shift_bits = 3'd2;
			end
			default: begin
				row_bytes  = 13'((14'(width) + 14'd1) >> 1);
				per_m1     = 3'd1;
				shift_bits = 3'd4;
			end
		endcase
	end

	// ---------------- front end: row and byte counting ----------------
	// palette writes only land when nothing that still needs a lookup is in flight
	assign in_stall  = (operation == OP_STREAM) ? (s1_valid_q && !s1_fire)
	                                            : (s1_valid_q || s2_busy_q);
	assign in_fire   = in_valid && !in_stall;
	assign byte_fire = in_fire && (operation == OP_STREAM);
	assign pal_fire  = in_fire && (operation == OP_PALETTE);

	assign at_filter = (byte_column_q == 13'd0);
	assign x         = byte_column_q - 13'd1;
	assign x_in      = 32'(x) < LINE_BYTES;
	assign bc_next   = 14'(byte_column_q) + 14'd1;
	assign row_done  = bc_next > 14'(row_bytes);
	assign rc_next   = 17'(row_count_q) + 17'd1;
	assign img_done  = rc_next >= 17'(rows);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_column_q <= '0;
			row_count_q   <= '0;
			row_filter_q  <= '0;
		end else if (byte_fire) begin
			if (at_filter) begin
				byte_column_q <= 13'd1;
				row_filter_q  <= data_byte[2:0];
			end else if (row_done) begin
				byte_column_q <= '0;
				row_count_q   <= img_done ? 16'd0 : rc_next[15:0];
			end else begin
				byte_column_q <= bc_next[12:0];
			end
		end
	end

	// ---------------- line store ----------------
	assign mem_we = s1_fire && !s1_q.is_filt && s1_q.x_in;

	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[AW'(s1_q.x)] <= rec;
		if (byte_fire && !at_filter && x_in)
			rd_data_q <= line_mem[AW'(x)];
	end

	// ---------------- reconstruction stage ----------------
	assign s1_fire = s1_valid_q && (!s2_busy_q || s2_done);

	always_comb begin
		if (s1_q.up_zero)
			up = 8'd0;
		else if (s1_q.fwd)
			up = s1_q.fwd_data;
		else
			up = rd_data_q;
		rec = recon(s1_q.filt, s1_q.raw, left_q, up, ul_q);
	end

	always_ff @(posedge clk) begin
		if (byte_fire) begin
			s1_q.is_filt  <= at_filter;
			s1_q.bad_filt <= data_byte > 8'(FILT_PAETH);
			s1_q.raw      <= data_byte;
			s1_q.filt     <= row_filter_q;
			s1_q.up_zero  <= (row_count_q == 16'd0) || !x_in;
			// same entry written by the byte ahead in this edge (one-byte rows)
			s1_q.fwd      <= mem_we && (s1_q.x == x);
			s1_q.fwd_data <= rec;
			s1_q.x        <= x;
			s1_q.x_in     <= x_in;
			s1_q.row_last <= img_done;
			s1_q.img_end  <= !at_filter && row_done && img_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			left_q     <= '0;
			ul_q       <= '0;
		end else begin
			if (byte_fire)
				s1_valid_q <= 1'b1;
			else if (s1_fire)
				s1_valid_q <= 1'b0;
			if (s1_fire) begin
				if (s1_q.is_filt) begin
					left_q <= '0;
					ul_q   <= '0;
				end else begin
					left_q <= rec;
					ul_q   <= up;
				end
			end
		end
	end

	// ---------------- unpacker ----------------
	assign out_ready = !out_valid_q || !out_stall;

	always_comb begin
		unique case (depth_code_q)
			DEPTH_1: idx = {3'b000, s2_q.pix[7]};
			DEPTH_2: idx = {2'b00, s2_q.pix[7:6]};
			default: idx = s2_q.pix[7:4];
		endcase
		bad_idx   = 5'(idx) >= pal;
		eor       = (14'(pix_col_q) + 14'd1) >= 14'(width);
		pix_last  = (k_q == per_m1) || eor;
		pal_entry = (32'(idx) < PALETTE_DEPTH) ? palette_q[idx[PW-1:0]] : 32'd0;
	end

	always_comb begin
		emit     = 1'b0;
		s2_done  = 1'b0;
		err_kind = ERR_NONE;
		if (s2_busy_q) begin
			if (s2_q.is_filt) begin
				if (!err_latch_q && s2_q.bad_filt) begin
					emit     = out_ready;
					s2_done  = out_ready;
					err_kind = ERR_FILTER;
				end else begin
					s2_done = 1'b1;
				end
			end else if (err_latch_q || pix_col_q >= width) begin
				s2_done = 1'b1;
			end else begin
				emit     = out_ready;
				err_kind = bad_idx ? ERR_INDEX : ERR_NONE;
				s2_done  = out_ready && (bad_idx || pix_last);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			s2_q.is_filt  <= s1_q.is_filt;
			s2_q.bad_filt <= s1_q.bad_filt;
			s2_q.pix      <= rec;
			s2_q.row_last <= s1_q.row_last;
			s2_q.img_end  <= s1_q.img_end;
		end else if (emit) begin
			s2_q.pix <= s2_q.pix << shift_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_busy_q   <= 1'b0;
			k_q         <= '0;
			pix_col_q   <= '0;
			err_latch_q <= 1'b0;
		end else begin
			if (s1_fire) begin
				s2_busy_q <= 1'b1;
				k_q       <= '0;
			end else begin
				if (s2_done)
					s2_busy_q <= 1'b0;
				if (emit)
					k_q <= k_q + 3'd1;
			end

			if (s2_busy_q && s2_q.is_filt && s2_done)
				pix_col_q <= '0;
			else if (emit && err_kind == ERR_NONE)
				pix_col_q <= pix_col_q + 13'd1;

			// end of image releases the drop, even after an error in the same byte
			if (s2_done && s2_q.img_end)
				err_latch_q <= 1'b0;
			else if (emit && err_kind != ERR_NONE)
				err_latch_q <= 1'b1;
		end
	end

	// palette
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PALETTE_DEPTH; i++)
				palette_q[i] <= '0;
		end else if (pal_fire && 32'(entry_index) < PALETTE_DEPTH) begin
			palette_q[entry_index[PW-1:0]] <= {entry_red, entry_green, entry_blue, entry_alpha};
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (err_kind != ERR_NONE) begin
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
				alpha_q <= '0;
				eor_q   <= 1'b0;
				eoi_q   <= 1'b0;
				last_q  <= 1'b1;
			end else begin
				red_q   <= pal_entry[31:24];
				green_q <= pal_entry[23:16];
				blue_q  <= pal_entry[15:8];
				alpha_q <= pal_entry[7:0];
				eor_q   <= eor;
				eoi_q   <= eor && s2_q.row_last;
				last_q  <= pix_last;
			end
			err_q <= err_kind;
		end
	end

	assign out_valid    = out_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign alpha        = alpha_q;
	assign end_of_row   = eor_q;
	assign end_of_image = eoi_q;
	assign last         = last_q;
	assign error_code   = err_q;

endmodule

`default_nettype wire

// ===== sim/png_unfilter_palette_expand_core_tb.sv =====
// Self-checking testbench for png_unfilter_palette_expand_core: palette loads, filtered
// scanline bytes and register writes against a cycle-free predictor of the RGBA pixels.
// Depends on pngupe_pkg (op, register and error codes, filter and depth constants).

module png_unfilter_palette_expand_core_tb;
	import pngupe_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 5;
	localparam int LINE_BYTES   = 2048;
	localparam int PAL_ENTRIES  = 16;
	localparam int MAX_WIDTH    = 4096;
	localparam int IDLE_WAIT    = 32;
	localparam int STALL_LIMIT  = 3000;
	localparam int LONG_HOLD    = 400;
	localparam int RANDOM_ITEMS = 370;

	localparam logic [7:0] FILT_NONE_BYTE = 8'd0;
	localparam logic [7:0] FILT_FIRST_BAD = 8'd5;
	localparam logic [7:0] FILT_LAST_BAD  = 8'd255;
	localparam logic [1:0] DEPTH_4        = 2'd2;

	typedef struct {
		op_t        op;
		logic [3:0] pal_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] data;
	} stream_item_t;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       eor;
		logic       eoi;
		logic       last;
		err_t       code;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = 1'b0;
	logic [3:0]  entry_index = '0;
	logic [7:0]  entry_red = '0;
	logic [7:0]  entry_green = '0;
	logic [7:0]  entry_blue = '0;
	logic [7:0]  entry_alpha = '0;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  red, green, blue, alpha;
	logic        end_of_row, end_of_image, last;
	logic [1:0]  error_code;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state
	logic [12:0] reg_row_pixels = 13'd1;
	logic [15:0] reg_image_rows = 16'd1;
	logic [1:0]  reg_depth = 2'd0;
	logic [4:0]  reg_pal = 5'd16;
	logic [7:0]  line_store [LINE_BYTES];
	logic [31:0] palette [PAL_ENTRIES];
	logic [7:0]  left_byte = '0;
	logic [7:0]  upleft_byte = '0;
	logic [2:0]  row_filter = '0;
	int unsigned byte_col = 0;
	int unsigned pix_col = 0;
	int unsigned row_cnt = 0;
	bit          drop_image = 1'b0;

	stream_item_t pending_items[$];
	pixel_t       expected_pixels[$];
	stream_item_t cur_item;
	pixel_t       want_px;

	int items_queued = 0;
	int items_accepted = 0;
	int regs_written = 0;
	int results_checked = 0;
	int error_results = 0;
	int mismatch_count = 0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_run = 0;
	int free_run = 0;
	int hold_left = 0;
	int pick;
	bit long_hold_armed = 1'b0;
	bit long_hold_done = 1'b0;

	png_unfilter_palette_expand_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.entry_index(entry_index), .entry_red(entry_red), .entry_green(entry_green),
		.entry_blue(entry_blue), .entry_alpha(entry_alpha), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall), .red(red), .green(green),
		.blue(blue), .alpha(alpha), .end_of_row(end_of_row),
		.end_of_image(end_of_image), .last(last), .error_code(error_code),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic int unsigned eff_width();
		if (reg_row_pixels == 0) return 1;
		if (reg_row_pixels > MAX_WIDTH) return MAX_WIDTH;
		return reg_row_pixels;
	endfunction

	function automatic int unsigned eff_rows();
		return (reg_image_rows == 0) ? 1 : reg_image_rows;
	endfunction

	function automatic int unsigned eff_bits();
		case (reg_depth)
			DEPTH_1: return 1;
			DEPTH_2: return 2;
			default: return 4;
		endcase
	endfunction

	function automatic int unsigned row_len();
		return (eff_width() * eff_bits() + 7) / 8;
	endfunction

	function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		int p, da, db, dc;
		p  = int'(a) + int'(b) - int'(c);
		da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
		db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
		dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
		if (da <= db && da <= dc) return a;
		return (db <= dc) ? b : c;
	endfunction

	function automatic void push_error(err_t code);
		pixel_t px;
		px = '{default: '0, code: code};
		px.last = 1'b1;
		expected_pixels.push_back(px);
	endfunction

	// Applies a palette item, or rebuilds one byte of the scanline and queues the pixels it yields.
	task automatic unfilter_and_expand(input stream_item_t it);
		int unsigned width, rows, bits, nbytes, pal, per, k, idx, x;
		logic [7:0] up, rec;
		logic [31:0] colour;
		pixel_t px;
		int n;
		if (it.op == OP_PALETTE) begin
			palette[it.pal_index] = {it.red, it.green, it.blue, it.alpha};
			return;
		end
		width = eff_width();
		rows = eff_rows();
		bits = eff_bits();
		nbytes = row_len();
		pal = (reg_pal > PAL_ENTRIES) ? PAL_ENTRIES : reg_pal;
		if (byte_col == 0) begin
			byte_col = 1;
			pix_col = 0;
			left_byte = '0;
			upleft_byte = '0;
			row_filter = it.data[2:0];
			if (!drop_image && it.data > 8'(FILT_PAETH)) begin
				drop_image = 1'b1;
				push_error(ERR_FILTER);
			end
			return;
		end
		x = byte_col - 1;
		up = (row_cnt != 0 && x < LINE_BYTES) ? line_store[x] : 8'd0;
		case (row_filter)
			FILT_SUB:   rec = it.data + left_byte;
			FILT_UP:    rec = it.data + up;
			FILT_AVG:   rec = it.data + 8'((9'(left_byte) + 9'(up)) >> 1);
			FILT_PAETH: rec = it.data + paeth_pick(left_byte, up, upleft_byte);
			default:    rec = it.data;
		endcase
		if (x < LINE_BYTES) line_store[x] = rec;
		left_byte = rec;
		upleft_byte = up;
		n = 0;
		if (!drop_image) begin
			per = 8 / bits;
			for (k = 0; k < per && pix_col < width; k++) begin
				idx = (32'(rec) >> (8 - bits * (k + 1))) & ((1 << bits) - 1);
				if (idx >= pal) begin
					drop_image = 1'b1;
					push_error(ERR_INDEX);
					n++;
					break;
				end
				colour = palette[idx];
				px.red = colour[31:24];
				px.green = colour[23:16];
				px.blue = colour[15:8];
				px.alpha = colour[7:0];
				px.eor = (pix_col + 1 >= width);
				px.eoi = px.eor && (row_cnt + 1 >= rows);
				px.last = 1'b0;
				px.code = ERR_NONE;
				expected_pixels.push_back(px);
				pix_col++;
				n++;
			end
			if (n > 0) expected_pixels[expected_pixels.size() - 1].last = 1'b1;
		end
		byte_col++;
		if (byte_col > nbytes) begin
			byte_col = 0;
			pix_col = 0;
			row_cnt++;
			if (row_cnt >= rows) begin
				row_cnt = 0;
				drop_image = 1'b0;
			end
		end
	endtask

	function automatic void queue_palette(logic [3:0] which, logic [31:0] rgba);
		stream_item_t it;
		it.op = OP_PALETTE;
		it.pal_index = which;
		{it.red, it.green, it.blue, it.alpha} = rgba;
		it.data = 8'($urandom);
		pending_items.push_back(it);
		items_queued++;
	endfunction

	// entry fields of a stream byte carry junk the block must ignore
	function automatic void queue_byte(logic [7:0] value);
		stream_item_t it;
		it.op = OP_STREAM;
		it.pal_index = 4'($urandom);
		{it.red, it.green, it.blue, it.alpha} = $urandom;
		it.data = value;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (pick < 55) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				unfilter_and_expand(cur_item);
				items_accepted++;
				gap_left = next_gap();
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					operation <= cur_item.op;
					entry_index <= cur_item.pal_index;
					entry_red <= cur_item.red;
					entry_green <= cur_item.green;
					entry_blue <= cur_item.blue;
					entry_alpha <= cur_item.alpha;
					data_byte <= cur_item.data;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off when armed
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (long_hold_armed && !long_hold_done) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (stall_run > 0) begin
				stall_run--;
				out_stall <= 1'b1;
			end else if (free_run > 0) begin
				free_run--;
				out_stall <= 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 30) free_run = $urandom_range(5, 60);
				else if (pick < 85) stall_run = $urandom_range(1, 3);
				else if (pick < 97) stall_run = $urandom_range(4, 12);
				else stall_run = $urandom_range(20, 40);
				out_stall <= 1'b0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel transfer with nothing pending: rgba %h%h%h%h error_code %0d",
					red, green, blue, alpha, error_code);
				mismatch_count++;
			end else begin
				want_px = expected_pixels.pop_front();
				check_field("red", want_px.red, red);
				check_field("green", want_px.green, green);
				check_field("blue", want_px.blue, blue);
				check_field("alpha", want_px.alpha, alpha);
				check_field("end_of_row", want_px.eor, end_of_row);
				check_field("end_of_image", want_px.eoi, end_of_image);
				check_field("last", want_px.last, last);
				check_field("error_code", want_px.code, error_code);
				results_checked++;
				if (want_px.code != ERR_NONE) error_results++;
			end
		end
	end

	// watchdog: too long without any transfer on any channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	task automatic write_reg(input cfg_idx_t which, input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (which)
			CFG_ROW_PIXELS:   reg_row_pixels = value[12:0];
			CFG_IMAGE_ROWS:   reg_image_rows = value;
			CFG_DEPTH_CODE:   reg_depth = value[1:0];
			CFG_PALETTE_SIZE: reg_pal = value[4:0];
		endcase
		regs_written++;
	endtask

	task automatic wait_idle();
		while (items_accepted != items_queued || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic set_geometry(input int width, input int rows, input logic [1:0] depth,
			input int pal);
		write_reg(CFG_ROW_PIXELS, {3'($urandom), 13'(width)});
		write_reg(CFG_IMAGE_ROWS, 16'(rows));
		write_reg(CFG_DEPTH_CODE, {14'($urandom), depth});
		write_reg(CFG_PALETTE_SIZE, {11'($urandom), 5'(pal)});
	endtask

	initial begin
		int unsigned nrows, nbytes, random_items, r, b;
		for (int i = 0; i < PAL_ENTRIES; i++) palette[i] = '0;
		random_items = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: one pixel, one bit, palette still all zero
		queue_byte(FILT_NONE_BYTE);
		queue_byte(8'h80);
		wait_idle();

		queue_palette(4'd0, 32'h0000_0000);
		queue_palette(4'd15, 32'hFFFF_FFFF);
		for (int i = 1; i < PAL_ENTRIES - 1; i++) queue_palette(4'(i), $urandom);
		wait_idle();

		// every filter once, four bits per index, last nibble past the row end
		set_geometry(1, 5, DEPTH_4, PAL_ENTRIES);
		queue_byte(FILT_NONE_BYTE);
		queue_byte(8'hFF);
		queue_byte(8'(FILT_SUB));
		queue_byte(8'h00);
		queue_byte(8'(FILT_UP));
		queue_byte(8'($urandom));
		queue_byte(8'(FILT_AVG));
		queue_byte(8'($urandom));
		queue_byte(8'(FILT_PAETH));
		queue_byte(8'($urandom));
		wait_idle();

		// bad filter drops the image; palette writes still go through meanwhile
		set_geometry(8, 2, DEPTH_1, PAL_ENTRIES);
		queue_byte(FILT_LAST_BAD);
		queue_byte(8'hAA);
		queue_palette(4'd3, $urandom);
		queue_byte(FILT_NONE_BYTE);
		queue_byte(8'h55);
		queue_byte(FILT_FIRST_BAD);
		queue_byte(8'($urandom));
		queue_byte(FILT_NONE_BYTE);
		queue_byte(8'($urandom));
		wait_idle();

		// index beyond palette in mid-byte, then an empty palette
		set_geometry(4, 1, DEPTH_2, 2);
		queue_byte(FILT_NONE_BYTE);
		queue_byte(8'b01_00_10_11);
		wait_idle();
		write_reg(CFG_PALETTE_SIZE, 16'd0);
		queue_byte(FILT_NONE_BYTE);
		queue_byte(8'($urandom));
		wait_idle();

		// tallest image, cut short by lowering the row count while in progress
		set_geometry(5, 65535, DEPTH_1, PAL_ENTRIES);
		for (int i = 0; i < 3; i++) begin
			queue_byte(8'($urandom_range(FILT_NONE_BYTE, FILT_PAETH)));
			queue_byte(8'($urandom));
		end
		wait_idle();
		write_reg(CFG_IMAGE_ROWS, 16'd2);
		write_reg(CFG_PALETTE_SIZE, 16'd31);
		queue_byte(8'(FILT_PAETH));
		queue_byte(8'($urandom));
		wait_idle();

		// random images, mostly well formed
		while (random_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 10) b = 0;
			else if (r < 95) b = $urandom_range(1, 20);
			else b = $urandom_range(21, 64);
			set_geometry(b, $urandom_range(0, 4), 2'($urandom),
				($urandom_range(0, 99) < 75) ? $urandom_range(16, 31)
					: $urandom_range(0, 16));
			nrows = eff_rows();
			nbytes = row_len();
			for (int row = 0; row < nrows; row++) begin
				if ($urandom_range(0, 99) < 15) queue_palette(4'($urandom), $urandom);
				if ($urandom_range(0, 99) < 92)
					queue_byte(8'($urandom_range(FILT_NONE_BYTE, FILT_PAETH)));
				else
					queue_byte(8'($urandom_range(FILT_FIRST_BAD, FILT_LAST_BAD)));
				random_items++;
				for (int k = 0; k < nbytes; k++) begin
					if ($urandom_range(0, 99) < 5) queue_palette(4'($urandom), $urandom);
					queue_byte(8'($urandom));
					random_items++;
				end
			end
			wait_idle();
		end

		// a row of one-bit indices while the receiver holds off for a long stretch
		write_reg(CFG_ROW_PIXELS, 16'd96);
		write_reg(CFG_IMAGE_ROWS, 16'd1);
		write_reg(CFG_DEPTH_CODE, {14'd0, DEPTH_1});
		write_reg(CFG_PALETTE_SIZE, 16'd16);
		queue_byte(8'(FILT_AVG));
		for (int k = 0; k < row_len(); k++) queue_byte(8'($urandom));
		long_hold_armed = 1'b1;
		wait_idle();

		$display("Covered %0d input transfers and %0d register writes,", items_accepted,
			regs_written);
		$display("checking %0d pixel results, %0d of them error results.", results_checked,
			error_results);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/pngupe_pkg.sv
hdl/png_unfilter_palette_expand_core.sv
sim/png_unfilter_palette_expand_core_tb.sv
